// ----- hdl/i2cmbe_pkg.sv -----
`timescale 1ns / 1ps

package i2cmbe_pkg;

   localparam int BYTE_BITS   = 8;
   localparam int BIT_COUNT_W = 4;
   localparam int HALF_W      = 16;

   localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd4;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_STOP  = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      STEP_IDLE     = 4'd0,
      STEP_PRELOW   = 4'd1,
      STEP_START_A  = 4'd2,
      STEP_START_B  = 4'd3,
      STEP_START_C  = 4'd4,
      STEP_STOP_A   = 4'd5,
      STEP_STOP_B   = 4'd6,
      STEP_WR_LOW   = 4'd7,
      STEP_WR_HIGH  = 4'd8,
      STEP_ACK_LOW  = 4'd9,
      STEP_ACK_HIGH = 4'd10,
      STEP_RD_LOW   = 4'd11,
      STEP_RD_HIGH  = 4'd12,
      STEP_RA_LOW   = 4'd13,
      STEP_RA_HIGH  = 4'd14
   } step_type;

   typedef struct packed {
      logic                 command_valid;
      op_type               operation;
      logic [BYTE_BITS-1:0] write_data;
      logic                 send_nack;
      logic                 sda_in;
   } req_payload_type;

   typedef struct packed {
      logic                 scl_release;
      logic                 sda_release;
      logic                 busy_res;
      logic                 done_res;
      logic [BYTE_BITS-1:0] read_data;
      logic                 ack_seen;
   } rsp_payload_type;

   // first step of a command body; for all but a start, taken once the clock is low
   function automatic step_type first_body_step(input op_type op);
      step_type s;
      case (op)
         OP_STOP:  s = STEP_STOP_A;
         OP_WRITE: s = STEP_WR_LOW;
         OP_READ:  s = STEP_RD_LOW;
         default:  s = STEP_START_A;
      endcase
      return s;
   endfunction

endpackage

// ----- hdl/i2cmbe_chan_if.sv -----
`timescale 1ns / 1ps

interface i2cmbe_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/i2c_master_bit_engine.sv -----
`timescale 1ns / 1ps

// channel   modport  payload            meaning
// req_ch    sink     req_payload_type   one request per bus tick: command offer and sda level
// rsp_ch    source   rsp_payload_type   one result per request: line drives, status, data
// csr_*     write    16 bit             half_period_ticks, ticks per scl half cycle
//
// each request is handled as it is accepted: the engine state and the result register load
// together on the accepting edge, so a request can be taken every cycle unless rsp_ch stalls
// the result register parts the sides: a request is taken while a result waits,
// as long as rsp_ch.ready is high in that cycle (result taken as the new one loads)
// reset (synchronous, active high) returns the engine to idle with scl driven low,
// sda released, half period 4, and clears the result register valid
module i2c_master_bit_engine
   import i2cmbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   i2cmbe_chan_if.sink           req_ch,
   i2cmbe_chan_if.source         rsp_ch,
   input  logic                  csr_write_enable,
   input  logic [HALF_W-1:0]     csr_write_data
);

   // configuration
   logic [HALF_W-1:0]      half_ff;

   // engine state
   step_type               step_ff, step_in;
   op_type                 cmd_ff, cmd_in;
   logic                   clk_ff, clk_in;
   logic                   dat_ff, dat_in;
   logic [BIT_COUNT_W-1:0] bits_ff, bits_in;
   logic [BYTE_BITS-1:0]   shift_ff, shift_in;
   logic [HALF_W-1:0]      tick_ff, tick_in;
   logic                   nack_ff, nack_in;
   logic                   ack_ff, ack_in;
   logic [BYTE_BITS-1:0]   rdata_ff, rdata_in;
   logic                   acted_ff, acted_in;
   logic                   done_in;

   // result register
   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_ff;

   logic                   req_fire;
   logic [HALF_W-1:0]      half_eff;
   req_payload_type        req_p;

   assign req_p          = req_ch.payload;
   assign req_ch.ready   = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire       = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   // zero half period behaves as one
   assign half_eff = (half_ff == '0) ? HALF_W'(1) : half_ff;

   always_comb begin
      step_in  = step_ff;
      cmd_in   = cmd_ff;
      clk_in   = clk_ff;
      dat_in   = dat_ff;
      bits_in  = bits_ff;
      shift_in = shift_ff;
      tick_in  = tick_ff;
      nack_in  = nack_ff;
      ack_in   = ack_ff;
      rdata_in = rdata_ff;
      acted_in = acted_ff;
      done_in  = 1'b0;

      if (step_ff == STEP_IDLE || step_ff > STEP_RA_HIGH) begin
         // idle, also any unused step code
         step_in = STEP_IDLE;
         if (req_p.command_valid) begin
            cmd_in   = req_p.operation;
            bits_in  = '0;
            tick_in  = '0;
            acted_in = 1'b0;
            nack_in  = req_p.send_nack;
            if (req_p.operation == OP_WRITE) begin
               shift_in = req_p.write_data;
            end
            // clock left high: pull it low first, except for a start
            if (req_p.operation != OP_START && clk_ff) begin
               step_in = STEP_PRELOW;
            end else begin
               step_in = first_body_step(req_p.operation);
            end
         end
      end else begin
         // data line action at mid slot, once per slot
         if (!acted_ff && tick_ff >= (half_eff >> 1)) begin
            acted_in = 1'b1;
            unique case (step_ff) inside
               STEP_START_A, STEP_STOP_B, STEP_ACK_LOW, STEP_RD_LOW: begin
                  dat_in = 1'b1;
               end
               STEP_START_C, STEP_STOP_A: begin
                  dat_in = 1'b0;
               end
               STEP_WR_LOW: begin
                  dat_in = shift_ff[BYTE_BITS-1];
               end
               STEP_ACK_HIGH: begin
                  ack_in = req_p.sda_in;
               end
               STEP_RD_HIGH: begin
                  shift_in = {shift_ff[BYTE_BITS-2:0], req_p.sda_in};
               end
               STEP_RA_LOW: begin
                  dat_in = nack_ff;
               end
               default: begin
               end
            endcase
         end

         // slot end: toggle scl (except in STEP_STOP_B) and advance (action above comes first)
         if (tick_ff >= half_eff - HALF_W'(1)) begin
            tick_in  = '0;
            acted_in = 1'b0;
            if (step_ff != STEP_STOP_B) begin
               clk_in = !clk_ff;
            end
            case (step_ff) inside
               STEP_PRELOW:  step_in = first_body_step(cmd_ff);
               STEP_START_A: step_in = clk_in ? STEP_START_C : STEP_START_B;
               STEP_START_B: step_in = STEP_START_C;
               STEP_STOP_A:  step_in = STEP_STOP_B;
               STEP_WR_LOW:  step_in = STEP_WR_HIGH;
               STEP_WR_HIGH: begin
                  shift_in = {shift_in[BYTE_BITS-2:0], 1'b0};
                  bits_in  = bits_ff + BIT_COUNT_W'(1);
                  step_in  = (bits_in >= BIT_COUNT_W'(BYTE_BITS)) ? STEP_ACK_LOW
                                                                   : STEP_WR_LOW;
               end
               STEP_ACK_LOW: step_in = STEP_ACK_HIGH;
               STEP_RD_LOW:  step_in = STEP_RD_HIGH;
               STEP_RD_HIGH: begin
                  bits_in = bits_ff + BIT_COUNT_W'(1);
                  if (bits_in >= BIT_COUNT_W'(BYTE_BITS)) begin
                     rdata_in = shift_in;
                     step_in  = STEP_RA_LOW;
                  end else begin
                     step_in  = STEP_RD_LOW;
                  end
               end
               STEP_RA_LOW:  step_in = STEP_RA_HIGH;
               default: begin
                  // last slot of the command
                  step_in = STEP_IDLE;
                  done_in = 1'b1;
               end
            endcase
         end else begin
            tick_in = tick_ff + HALF_W'(1);
         end
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= HALF_PERIOD_RESET;
      end else if (csr_write_enable) begin
         half_ff <= csr_write_data;
      end
   end

   // engine state advances one tick per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_IDLE;
         cmd_ff   <= OP_START;
         clk_ff   <= 1'b0;
         dat_ff   <= 1'b1;
         bits_ff  <= '0;
         shift_ff <= '0;
         tick_ff  <= '0;
         nack_ff  <= 1'b0;
         ack_ff   <= 1'b1;
         rdata_ff <= '0;
         acted_ff <= 1'b0;
      end else if (req_fire) begin
         step_ff  <= step_in;
         cmd_ff   <= cmd_in;
         clk_ff   <= clk_in;
         dat_ff   <= dat_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
         tick_ff  <= tick_in;
         nack_ff  <= nack_in;
         ack_ff   <= ack_in;
         rdata_ff <= rdata_in;
         acted_ff <= acted_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload shows the state after the tick
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff.scl_release <= clk_in;
         rsp_ff.sda_release <= dat_in;
         rsp_ff.busy_res    <= (step_in != STEP_IDLE);
         rsp_ff.done_res    <= done_in;
         rsp_ff.read_data   <= rdata_in;
         rsp_ff.ack_seen    <= ack_in;
      end
   end

endmodule
